[rtl/core/lpc_pkg.sv]
// shared constants and types for the lidar point to cartesian core
package lpc_pkg;

	localparam int unsigned TRIG_FRAC_BITS = 15;
	localparam int unsigned TW = TRIG_FRAC_BITS + 1;

	localparam int unsigned TURN = 36000;
	localparam int unsigned QUARTER = 9000;
	localparam int unsigned OCTANT = 4500;

	localparam int unsigned SER = 30;
	localparam logic [63:0] PI_Q48 = 64'h3243F6A8885A3;
	localparam logic [63:0] DEN = 64'd18000 << 18;
	localparam logic [17:0] CI = 18'(PI_Q48 / DEN);
	localparam logic [32:0] CR = 33'(PI_Q48 % DEN);
	localparam logic [31:0] DEN_HALF = 32'(DEN >> 1);
	localparam logic [24:0] M1125 = 25'(((64'd1 << 35) + 64'd1124) / 64'd1125);
	localparam int unsigned K1125 = 35;

	localparam int unsigned NS = 5;
	localparam int unsigned NC = 6;
	localparam logic [31:0] SIN_M [NS] = '{
		32'(((64'd1 << 33) + 64'd5) / 64'd6),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 37) + 64'd109) / 64'd110)
	};
	localparam int unsigned SIN_K [NS] = '{33, 35, 36, 37, 37};
	localparam logic [31:0] COS_M [NC] = '{
		32'(((64'd1 << 31) + 64'd1) / 64'd2),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 37) + 64'd89) / 64'd90),
		32'(((64'd1 << 38) + 64'd131) / 64'd132)
	};
	localparam int unsigned COS_K [NC] = '{31, 34, 35, 36, 37, 38};

	localparam int unsigned TRIG_LAT = 21;
	localparam int unsigned DEPTH = TRIG_LAT + 5;

	localparam logic [0:0] REG_ELEV_OFFSET = 1'b0;
	localparam logic [13:0] ELEV_OFFSET_RESET = 14'd1500;

	typedef struct packed {
		logic [TW-1:0] sm;
		logic sn;
		logic [TW-1:0] cm;
		logic cn;
	} trig_t;

	typedef struct packed {
		logic [1:0] q;
		logic swap;
	} oct_t;

endpackage

[rtl/core/lpc_trig.sv]
// pipelined sine and cosine of an angle in hundredths of a degree
module lpc_trig import lpc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle,
	output trig_t       res
);

	localparam int unsigned XW = 30;
	localparam int unsigned TMW = 31;
	localparam int unsigned PW = 61;
	localparam int unsigned QW = 63;
	localparam int unsigned AW = 33;

	oct_t oct_c;
	logic [13:0] r_c;
	oct_t oct_s1, oct_s2, oct_s3, oct_s4, oct_s5, oct_s6, oct_s7, oct_s20;
	logic [13:0] r_s1;
	logic [12:0] rr_s2;
	logic [29:0] a1_s3, a1_s4;
	logic [45:0] b1_s3;
	logic [49:0] pm_s4;
	logic [XW-1:0] x_s5, x_s6, x_s7, x2_s7;
	logic [59:0] xx_s6;
	logic [TW-1:0] sr_s20, cr_s20;

	always_comb begin
		oct_c.swap = 1'b0;
		if (angle >= 16'(3 * QUARTER)) begin
			oct_c.q = 2'd3;
			r_c = 14'(angle - 16'(3 * QUARTER));
		end else if (angle >= 16'(2 * QUARTER)) begin
			oct_c.q = 2'd2;
			r_c = 14'(angle - 16'(2 * QUARTER));
		end else if (angle >= 16'(QUARTER)) begin
			oct_c.q = 2'd1;
			r_c = 14'(angle - 16'(QUARTER));
		end else begin
			oct_c.q = 2'd0;
			r_c = 14'(angle);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s1 <= oct_c;
			r_s1 <= r_c;
			oct_s2.q <= oct_s1.q;
			oct_s2.swap <= (r_s1 > 14'(OCTANT));
			rr_s2 <= (r_s1 > 14'(OCTANT)) ? 13'(14'(QUARTER) - r_s1) : 13'(r_s1);
			oct_s3 <= oct_s2;
			a1_s3 <= 30'(31'(rr_s2) * 31'(CI));
			b1_s3 <= 46'(rr_s2) * 46'(CR);
			oct_s4 <= oct_s3;
			a1_s4 <= a1_s3;
			pm_s4 <= 50'(25'((47'(b1_s3) + 47'(DEN_HALF)) >> 22)) * 50'(M1125);
			oct_s5 <= oct_s4;
			x_s5 <= a1_s4 + 30'(pm_s4 >> K1125);
			oct_s6 <= oct_s5;
			x_s6 <= x_s5;
			xx_s6 <= 60'(x_s5) * 60'(x_s5);
			oct_s7 <= oct_s6;
			x_s7 <= x_s6;
			x2_s7 <= XW'((61'(xx_s6) + (61'(1) << (SER - 1))) >> SER);
		end
	end

	// series iterations: two stages per term
	logic [PW-1:0] s_pa_s [NS];
	logic [QW-1:0] s_pb_s [NS];
	logic [PW-1:0] c_pa_s [NC];
	logic [QW-1:0] c_pb_s [NC];
	logic signed [AW-1:0] s_acca_s [NC];
	logic signed [AW-1:0] s_accb_s [NC];
	logic signed [AW-1:0] c_acca_s [NC];
	logic signed [AW-1:0] c_accb_s [NC];
	logic [XW-1:0] x2a_s [NC];
	logic [XW-1:0] x2b_s [NC];
	oct_t octa_s [NC];
	oct_t octb_s [NC];

	for (genvar j = 0; j < NC; j++) begin : g_it
		logic [TMW-1:0] ts, tc;
		logic signed [AW-1:0] as_n, ac_n;
		logic [XW-1:0] x2_in;
		oct_t oct_in;
		if (j == 0) begin : g_first
			assign ts = TMW'(x_s7);
			assign tc = TMW'(1) << SER;
			assign as_n = $signed(AW'(x_s7));
			assign ac_n = $signed(AW'(1) << SER);
			assign x2_in = x2_s7;
			assign oct_in = oct_s7;
		end else begin : g_next
			assign ts = TMW'(s_pb_s[j-1] >> SIN_K[j-1]);
			assign tc = TMW'(c_pb_s[j-1] >> COS_K[j-1]);
			assign as_n = (j % 2 == 1) ? s_accb_s[j-1] - $signed(AW'(ts))
				: s_accb_s[j-1] + $signed(AW'(ts));
			assign ac_n = (j % 2 == 1) ? c_accb_s[j-1] - $signed(AW'(tc))
				: c_accb_s[j-1] + $signed(AW'(tc));
			assign x2_in = x2b_s[j-1];
			assign oct_in = octb_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_acca_s[j] <= as_n;
				c_acca_s[j] <= ac_n;
				c_pa_s[j] <= PW'(tc) * PW'(x2_in);
				x2a_s[j] <= x2_in;
				octa_s[j] <= oct_in;
				s_accb_s[j] <= s_acca_s[j];
				c_accb_s[j] <= c_acca_s[j];
				c_pb_s[j] <= QW'(TMW'(c_pa_s[j] >> SER)) * QW'(COS_M[j]);
				x2b_s[j] <= x2a_s[j];
				octb_s[j] <= octa_s[j];
			end
		end

		if (j < NS) begin : g_sin
			always_ff @(posedge clk) begin
				if (en) begin
					s_pa_s[j] <= PW'(ts) * PW'(x2_in);
					s_pb_s[j] <= QW'(TMW'(s_pa_s[j] >> SER)) * QW'(SIN_M[j]);
				end
			end
		end
	end

	logic [AW-1:0] sv_c, cv_c;
	assign sv_c = AW'(s_accb_s[NC-1]);
	assign cv_c = AW'(c_accb_s[NC-1] + $signed(AW'(TMW'(c_pb_s[NC-1] >> COS_K[NC-1]))));

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s20 <= octb_s[NC-1];
			sr_s20 <= TW'((sv_c + (AW'(1) << (SER - 1 - TRIG_FRAC_BITS)))
				>> (SER - TRIG_FRAC_BITS));
			cr_s20 <= TW'((cv_c + (AW'(1) << (SER - 1 - TRIG_FRAC_BITS)))
				>> (SER - TRIG_FRAC_BITS));
		end
	end

	logic [TW-1:0] s0, c0;
	trig_t res_c;
	always_comb begin
		s0 = oct_s20.swap ? cr_s20 : sr_s20;
		c0 = oct_s20.swap ? sr_s20 : cr_s20;
		case (oct_s20.q)
			2'd0: res_c = '{sm: s0, sn: 1'b0, cm: c0, cn: 1'b0};
			2'd1: res_c = '{sm: c0, sn: 1'b0, cm: s0, cn: 1'b1};
			2'd2: res_c = '{sm: s0, sn: 1'b1, cm: c0, cn: 1'b1};
			default: res_c = '{sm: c0, sn: 1'b1, cm: s0, cn: 1'b0};
		endcase
		if (res_c.sm == '0) res_c.sn = 1'b0;
		if (res_c.cm == '0) res_c.cn = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_c;
		end
	end

endmodule

[rtl/core/lidar_point_to_cartesian_core.sv]
// top level of the lidar point to cartesian core
// Converts one lidar return per item from azimuth, elevation and range
// into x, y and z in 1/500 m units, with the intensity copied through.
// Input channel: in_valid/in_ready with azimuth_raw, elevation_raw,
// distance_raw and intensity_raw. Output channel: out_valid/out_ready with
// x_coord, y_coord, z_coord and intensity_out.
// The elevation offset register sits at byte address 0 of the APB port;
// write it only while no item is in flight.
// An accepted item passes angle reduction, both trig pipelines, the products
// and the output register. One item is taken every cycle while out_ready is
// high; the series pipeline for sine and cosine (two stages per term) sets
// the depth. When the receiver stalls with a result waiting, the whole
// pipeline holds and in_ready drops; no item is lost or repeated.
// Reset clears all valid bits and loads the offset with 1500.
module lidar_point_to_cartesian_core import lpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        azimuth_raw,
	input  logic [15:0]        elevation_raw,
	input  logic [15:0]        distance_raw,
	input  logic [15:0]        intensity_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] x_coord,
	output logic signed [16:0] y_coord,
	output logic signed [16:0] z_coord,
	output logic [15:0]        intensity_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned DW = 16 + TW;
	localparam int unsigned PXW = 16 + 2 * TW;

	logic [13:0] elev_off_q;
	logic [DEPTH-1:0] vld_q;
	logic en;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ELEV_OFFSET) ? {18'd0, elev_off_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elev_off_q <= ELEV_OFFSET_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ELEV_OFFSET) begin
			elev_off_q <= pwdata[13:0];
		end
	end

	assign en = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// angle reduction
	logic [15:0] az_s1, er_s1, az_s2, el_s2;
	logic [16:0] el_t;
	logic [15:0] dist_s [TRIG_LAT + 2];
	logic [15:0] inten_s [DEPTH];

	assign el_t = 17'(er_s1) + 17'(TURN) - 17'(elev_off_q);

	always_ff @(posedge clk) begin
		if (en) begin
			az_s1 <= (azimuth_raw >= 16'(TURN)) ? azimuth_raw - 16'(TURN) : azimuth_raw;
			er_s1 <= (elevation_raw >= 16'(TURN)) ? elevation_raw - 16'(TURN) : elevation_raw;
			az_s2 <= az_s1;
			el_s2 <= (el_t >= 17'(TURN)) ? 16'(el_t - 17'(TURN)) : 16'(el_t);
			dist_s[0] <= distance_raw;
			inten_s[0] <= intensity_raw;
		end
	end

	for (genvar i = 1; i < TRIG_LAT + 2; i++) begin : g_dist
		always_ff @(posedge clk) begin
			if (en) dist_s[i] <= dist_s[i-1];
		end
	end

	for (genvar i = 1; i < DEPTH; i++) begin : g_inten
		always_ff @(posedge clk) begin
			if (en) inten_s[i] <= inten_s[i-1];
		end
	end

	trig_t taz, tel;

	lpc_trig u_trig_az (
		.clk   (clk),
		.en    (en),
		.angle (az_s2),
		.res   (taz)
	);

	lpc_trig u_trig_el (
		.clk   (clk),
		.en    (en),
		.angle (el_s2),
		.res   (tel)
	);

	// products and rounding
	logic [DW-1:0] dc_s24, dz_s24, dz_s25;
	trig_t taz_s24;
	logic nx_s24, ny_s24, nz_s24, nx_s25, ny_s25, nz_s25;
	logic [PXW-1:0] px_s25, py_s25;
	logic [PXW-1:0] mx_c, my_c;
	logic [DW-1:0] mz_c;

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s24 <= DW'(dist_s[TRIG_LAT + 1]) * DW'(tel.cm);
			dz_s24 <= DW'(dist_s[TRIG_LAT + 1]) * DW'(tel.sm);
			taz_s24 <= taz;
			nx_s24 <= tel.cn ^ taz.sn;
			ny_s24 <= tel.cn ^ taz.cn;
			nz_s24 <= tel.sn;
			px_s25 <= PXW'(dc_s24) * PXW'(taz_s24.sm);
			py_s25 <= PXW'(dc_s24) * PXW'(taz_s24.cm);
			dz_s25 <= dz_s24;
			nx_s25 <= nx_s24;
			ny_s25 <= ny_s24;
			nz_s25 <= nz_s24;
		end
	end

	assign mx_c = (px_s25 + (PXW'(1) << (2 * TRIG_FRAC_BITS - 1))) >> (2 * TRIG_FRAC_BITS);
	assign my_c = (py_s25 + (PXW'(1) << (2 * TRIG_FRAC_BITS - 1))) >> (2 * TRIG_FRAC_BITS);
	assign mz_c = (dz_s25 + (DW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;

	logic [16:0] x_s26, y_s26, z_s26;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s26 <= nx_s25 ? 17'(-mx_c[16:0]) : mx_c[16:0];
			y_s26 <= ny_s25 ? 17'(-my_c[16:0]) : my_c[16:0];
			z_s26 <= nz_s25 ? 17'(-mz_c[16:0]) : mz_c[16:0];
		end
	end

	assign x_coord = $signed(x_s26);
	assign y_coord = $signed(y_s26);
	assign z_coord = $signed(z_s26);
	assign intensity_out = inten_s[DEPTH-1];

`ifndef SYNTH
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(intensity_out))
		else $error("stalled result changed");
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_coord != 17'sh10000 && y_coord != 17'sh10000)
		else $error("x or y out of range");
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> z_coord != 17'sh10000)
		else $error("z out of range");
`endif

endmodule
